FILE: hdl/bcc_pkg.sv
// Types and constants shared by the button click classifier modules.
`default_nettype none
package bcc_pkg;

	localparam int unsigned TickW  = 16;
	localparam int unsigned ClickW = 4;
	localparam int unsigned EventW = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [TickW-1:0]  TickMax  = '1;
	localparam logic [ClickW-1:0] ClickMax = '1;

	localparam logic [TickW-1:0] DebounceReset  = 16'd500;
	localparam logic [TickW-1:0] LongClickReset = 16'd1000;

	// Event codes carried on the result channel
	typedef enum logic [EventW-1:0] {
		EV_NONE   = 3'd0,
		EV_CLICK  = 3'd1,
		EV_LONG   = 3'd2,
		EV_DOUBLE = 3'd3,
		EV_MULTI  = 3'd4
	} bcc_event_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_ACTIVE_LEVEL = 2'd0,
		REG_DEBOUNCE     = 2'd1,
		REG_LONG_CLICK   = 2'd2
	} bcc_reg_t;

	typedef struct packed {
		logic              active_level;
		logic [TickW-1:0]  debounce_ticks;
		logic [TickW-1:0]  long_click_ticks;
	} bcc_cfg_t;

	typedef struct packed {
		logic              prev_level;
		logic [TickW-1:0]  ticks;
		logic [ClickW-1:0] clicks;
		bcc_event_t        pending;
	} bcc_state_t;

endpackage
`default_nettype wire

FILE: hdl/bcc_if.sv
// Valid/ready channel interfaces for the tick samples and the click results.
`default_nettype none
interface bcc_sample_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bcc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic [3:0] click_count;

	modport source (output valid, output event_code, output click_count, input ready);
	modport sink (input valid, input event_code, input click_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/bcc_tick_logic.sv
// Next-state logic of the classifier for one tick.
`default_nettype none
module bcc_tick_logic
	import bcc_pkg::*;
(
	input  bcc_cfg_t   cfg,
	input  bcc_state_t cur,
	input  logic       pin_level,
	output bcc_state_t nxt
);

	logic [TickW-1:0]  elapsed;
	logic [ClickW-1:0] clicks_base;
	logic              pressed;
	logic              press_edge;
	logic              gather;
	logic              resolve;
	bcc_event_t        kind;

	// Saturating tick count, clearing after a shown event, press and resolve decisions
	always_comb begin
		elapsed     = (cur.ticks == TickMax) ? cur.ticks : cur.ticks + 1'b1;
		clicks_base = (cur.pending != EV_NONE) ? '0 : cur.clicks;
		pressed     = (pin_level == cfg.active_level);
		press_edge  = pressed && (cur.prev_level != cfg.active_level);
		gather      = press_edge && ((clicks_base == '0) || (elapsed < cfg.debounce_ticks))
			&& (clicks_base != ClickMax);
		resolve     = !press_edge && !pressed && (clicks_base != '0)
			&& (elapsed >= cfg.debounce_ticks);
	end

	// Event kind from the clicks gathered
	always_comb begin
		case (clicks_base)
			4'd0:    kind = EV_NONE;
			4'd1:    kind = (elapsed > cfg.long_click_ticks) ? EV_LONG : EV_CLICK;
			4'd2:    kind = EV_DOUBLE;
			default: kind = EV_MULTI;
		endcase
	end

	always_comb begin
		nxt.prev_level = pin_level;
		nxt.ticks      = press_edge ? '0 : elapsed;
		nxt.clicks     = gather ? clicks_base + 1'b1 : clicks_base;
		nxt.pending    = resolve ? kind : EV_NONE;
	end

endmodule
`default_nettype wire

FILE: hdl/button_click_classifier_core.sv
// Top level of the button click classifier: state, configuration and result register.
//
// Usage: every sample item on "samples" is one tick carrying the pin level. For
// each accepted sample exactly one result item leaves on "events": the event code
// (none, click, long click, double click, multi click) and the clicks gathered in
// the current sequence. An event shows on exactly one result item.
// The result of a sample is in the output register in the cycle after the
// sample is accepted. Throughput: one sample per cycle while results are taken;
// the combinational tick counter, click counter and previous level update sets it.
// Stall: samples.ready is high while the result register is empty or being taken
// in the same cycle, so a stalled receiver holds the result and stops input after
// one waiting result.
// Reset (arst_n low): active level 0, debounce 500 ticks, long click 1000 ticks,
// previous level released, counters cleared, no result pending.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 active level,
// 1 debounce ticks, 2 long click ticks); other indexes are ignored. Write only
// while the block is idle.
`default_nettype none
module button_click_classifier_core
	import bcc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	bcc_sample_if.sink          samples,
	bcc_event_if.source         events
);

	bcc_cfg_t   cfg_q;
	bcc_state_t state_q;
	bcc_state_t state_nxt;
	logic       out_valid_q;
	bcc_event_t event_q;
	logic [ClickW-1:0] count_q;
	logic       in_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= 1'b0;
			cfg_q.debounce_ticks   <= DebounceReset;
			cfg_q.long_click_ticks <= LongClickReset;
		end else if (cfg_we) begin
			case (bcc_reg_t'(cfg_index))
				REG_ACTIVE_LEVEL: cfg_q.active_level     <= cfg_data[0];
				REG_DEBOUNCE:     cfg_q.debounce_ticks   <= cfg_data[TickW-1:0];
				REG_LONG_CLICK:   cfg_q.long_click_ticks <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	assign samples.ready = !out_valid_q || events.ready;
	assign in_take       = samples.valid && samples.ready;

	bcc_tick_logic u_tick (
		.cfg       (cfg_q),
		.cur       (state_q),
		.pin_level (samples.pin_level),
		.nxt       (state_nxt)
	);

	// Classifier state, updated once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev_level <= 1'b1;
			state_q.ticks      <= '0;
			state_q.clicks     <= '0;
			state_q.pending    <= EV_NONE;
		end else if (in_take) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			event_q <= state_nxt.pending;
			count_q <= state_nxt.clicks;
		end
	end

	assign events.valid       = out_valid_q;
	assign events.event_code  = event_q;
	assign events.click_count = count_q;

`ifndef SYNTHESIS
	// A pending event always comes with gathered clicks
	a_event_has_clicks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending != EV_NONE |-> state_q.clicks != '0)
		else $error("event pending with no clicks gathered");

	// An event never shows on two consecutive items
	a_event_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && state_q.pending != EV_NONE |=> state_q.pending == EV_NONE)
		else $error("event shown for more than one tick");

	// Long click only for a single click
	a_long_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q == EV_LONG |-> count_q == 4'd1)
		else $error("long click reported with click count other than one");
`endif

endmodule
`default_nettype wire
